[hw/rtl/sgr_pkg.sv]
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types, constants and palette/code helpers for the SGR color parser.
// ----------------------------------------------------------------------------
package sgr_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef logic [23:0] rgb_t;

    localparam rgb_t DEFAULT_FORE = 24'hC0C0C0;
    localparam rgb_t DEFAULT_BACK = 24'h000000;

    localparam logic [9:0] CODE_RESET     = 10'd0;
    localparam logic [9:0] CODE_BOLD      = 10'd1;
    localparam logic [9:0] CODE_BOLD_OFF  = 10'd22;
    localparam logic [9:0] CODE_FG_LO     = 10'd30;
    localparam logic [9:0] CODE_FG_HI     = 10'd37;
    localparam logic [9:0] CODE_BG_LO     = 10'd40;
    localparam logic [9:0] CODE_BG_HI     = 10'd47;
    localparam logic [9:0] CODE_FGB_LO    = 10'd90;
    localparam logic [9:0] CODE_FGB_HI    = 10'd97;
    localparam logic [9:0] CODE_BGB_LO    = 10'd100;
    localparam logic [9:0] CODE_BGB_HI    = 10'd107;

    // Attribute set: colors plus bold
    typedef struct packed {
        rgb_t fore;
        rgb_t back;
        logic bold;
    } sgr_attr_t;

    localparam sgr_attr_t ATTR_DEFAULT = '{fore: DEFAULT_FORE, back: DEFAULT_BACK, bold: 1'b0};

    // Work item handed from the parser to the emitter
    typedef struct packed {
        logic [7:0] out_byte;
        rgb_t       fore_rgb;
        rgb_t       back_rgb;
        logic       has_text;
        logic       has_end;
    } sgr_entry_t;

    function automatic rgb_t normal_pal(input logic [2:0] idx);
        rgb_t c;
        case (idx)
            3'd0:    c = 24'h000000;
            3'd1:    c = 24'h800000;
            3'd2:    c = 24'h008000;
            3'd3:    c = 24'h808000;
            3'd4:    c = 24'h000080;
            3'd5:    c = 24'h800080;
            3'd6:    c = 24'h008080;
            default: c = 24'hC0C0C0;
        endcase
        return c;
    endfunction

    function automatic rgb_t bright_pal(input logic [2:0] idx);
        rgb_t c;
        case (idx)
            3'd0:    c = 24'h808080;
            3'd1:    c = 24'hFF0000;
            3'd2:    c = 24'h00FF00;
            3'd3:    c = 24'hFFFF00;
            3'd4:    c = 24'h0000FF;
            3'd5:    c = 24'hFF00FF;
            3'd6:    c = 24'h00FFFF;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

    // One SGR code applied to a staged attribute set
    function automatic sgr_attr_t apply_code(input logic [9:0] code, input sgr_attr_t cur);
        sgr_attr_t  nxt;
        logic [9:0] off_fg;
        logic [9:0] off_bg;
        logic [9:0] off_fgb;
        logic [9:0] off_bgb;
        nxt     = cur;
        off_fg  = code - CODE_FG_LO;
        off_bg  = code - CODE_BG_LO;
        off_fgb = code - CODE_FGB_LO;
        off_bgb = code - CODE_BGB_LO;
        if (code == CODE_RESET) begin
            nxt = ATTR_DEFAULT;
        end else if (code == CODE_BOLD) begin
            nxt.bold = 1'b1;
        end else if (code == CODE_BOLD_OFF) begin
            nxt.bold = 1'b0;
        end else if (code >= CODE_FG_LO && code <= CODE_FG_HI) begin
            nxt.fore = cur.bold ? bright_pal(off_fg[2:0]) : normal_pal(off_fg[2:0]);
        end else if (code >= CODE_BG_LO && code <= CODE_BG_HI) begin
            nxt.back = normal_pal(off_bg[2:0]);
        end else if (code >= CODE_FGB_LO && code <= CODE_FGB_HI) begin
            nxt.fore = bright_pal(off_fgb[2:0]);
        end else if (code >= CODE_BGB_LO && code <= CODE_BGB_HI) begin
            nxt.back = bright_pal(off_bgb[2:0]);
        end
        return nxt;
    endfunction

endpackage

[hw/rtl/ansi_sgr_color_parser.sv]
// ----------------------------------------------------------------------------
// ansi_sgr_color_parser
// Strips ANSI SGR escape sequences from a byte stream and tags each byte
// with its 24-bit foreground and background colors.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats: s_tdata = text byte, s_tuser = byte present, s_tlast = end
//   of text. A beat with s_tuser low and s_tlast low is absorbed silently.
//   Output beats: one per displayable byte in the colors in force, and a
//   line-end beat (m_tuser high, byte zero) for every s_tlast; m_tlast marks
//   the final beat produced by one input beat.
//   Throughput: one input beat per clock while the queue is not full. An input
//   that yields a text byte and a line end takes two output beats, and the
//   emitter drains at most one beat per clock; the four-entry queue absorbs the difference.
//   Path: the queue is written at the accepting edge, and the emitter then
//   loads the output register from the queue head once that register is free.
//   Reset (rst_n low, async): text mode, fore 0xC0C0C0, back black, bold
//   off, queue empty, no output beat held.
//   Stall: a held m_tready low keeps the output beat stable; the queue
//   fills and s_tready drops once it is full.
// ----------------------------------------------------------------------------
module ansi_sgr_color_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte[7:0]
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_byte[7:0], fore_rgb[31:8], back_rgb[55:32]
    output logic        m_tuser,   // is_line_end
    output logic        m_tlast    // last_of_run
);

    logic                accept;
    logic                push;
    sgr_pkg::sgr_entry_t push_data;
    logic                pop;
    sgr_pkg::sgr_entry_t head;
    logic                not_empty;
    logic                full;

    // Parser stalls only on a full queue
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    sgr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (s_tdata),
        .byte_valid  (s_tuser),
        .end_of_text (s_tlast),
        .push        (push),
        .push_data   (push_data)
    );

    sgr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    sgr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (not_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

[hw/rtl/sgr_front.sv]
// ----------------------------------------------------------------------------
// sgr_front
// Escape-sequence parser: classifies each byte, tracks colors, posts work.
// ----------------------------------------------------------------------------
module sgr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         text_byte,
    input  logic               byte_valid,
    input  logic               end_of_text,
    output logic               push,
    output sgr_pkg::sgr_entry_t push_data
);

    localparam logic [1:0] MODE_TEXT  = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_PARAM = 2'd2;

    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_M       = 8'h6D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [13:0] ACC_MAX   = 14'd1023;

    logic [1:0]         mode_reg,  mode_next;
    sgr_pkg::sgr_attr_t cur_reg,   cur_next;
    sgr_pkg::sgr_attr_t pend_reg,  pend_next;
    logic [9:0]         acc_reg,   acc_next;
    logic               digit_reg, digit_next;
    logic               any_reg,   any_next;

    sgr_pkg::sgr_attr_t work;
    logic [13:0]        acc_wide;
    logic [9:0]         acc_sat;
    logic               is_digit;
    logic               to_text;
    logic               emit_text;
    sgr_pkg::sgr_attr_t out_attr;

    // acc*10 + digit as shifts and adds
    assign acc_wide = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {10'd0, text_byte[3:0]};
    assign acc_sat  = (acc_wide > ACC_MAX) ? ACC_MAX[9:0] : acc_wide[9:0];
    assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);

    always_comb
    begin
        mode_next  = mode_reg;
        cur_next   = cur_reg;
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        digit_next = digit_reg;
        any_next   = any_reg;
        work       = pend_reg;
        to_text    = 1'b0;
        emit_text  = 1'b0;

        if (byte_valid)
        begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    if (text_byte == CH_LBRACK)
                    begin
                        mode_next  = MODE_PARAM;
                        pend_next  = cur_reg;
                        acc_next   = 10'd0;
                        digit_next = 1'b0;
                        any_next   = 1'b0;
                    end
                    else
                    begin
                        to_text = 1'b1;
                    end
                end
                MODE_PARAM:
                begin
                    if (is_digit)
                    begin
                        acc_next   = acc_sat;
                        digit_next = 1'b1;
                    end
                    else if (text_byte == CH_SEMI || text_byte == CH_M)
                    begin
                        if (digit_reg)
                        begin
                            work = sgr_pkg::apply_code(acc_reg, pend_reg);
                        end
                        acc_next   = 10'd0;
                        digit_next = 1'b0;
                        any_next   = any_reg | digit_reg;
                        if (text_byte == CH_M)
                        begin
                            // empty list acts as a reset
                            if (!(any_reg | digit_reg))
                            begin
                                work = sgr_pkg::ATTR_DEFAULT;
                            end
                            cur_next  = work;
                            any_next  = 1'b0;
                            mode_next = MODE_TEXT;
                        end
                        pend_next = work;
                    end
                    else
                    begin
                        to_text = 1'b1;
                    end
                end
                default:
                begin
                    to_text = 1'b1;
                end
            endcase

            if (to_text)
            begin
                if (text_byte == CH_ESC)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    mode_next = MODE_TEXT;
                    emit_text = 1'b1;
                end
            end
        end

        // colors seen by this item's results
        out_attr = cur_next;

        if (end_of_text)
        begin
            mode_next  = MODE_TEXT;
            cur_next   = sgr_pkg::ATTR_DEFAULT;
            pend_next  = sgr_pkg::ATTR_DEFAULT;
            acc_next   = 10'd0;
            digit_next = 1'b0;
            any_next   = 1'b0;
        end
    end

    assign push               = accept && (emit_text || end_of_text);
    assign push_data.out_byte = text_byte;
    assign push_data.fore_rgb = out_attr.fore;
    assign push_data.back_rgb = out_attr.back;
    assign push_data.has_text = emit_text;
    assign push_data.has_end  = end_of_text;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TEXT;
            cur_reg   <= sgr_pkg::ATTR_DEFAULT;
            pend_reg  <= sgr_pkg::ATTR_DEFAULT;
            acc_reg   <= 10'd0;
            digit_reg <= 1'b0;
            any_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            cur_reg   <= cur_next;
            pend_reg  <= pend_next;
            acc_reg   <= acc_next;
            digit_reg <= digit_next;
            any_reg   <= any_next;
        end
    end

endmodule

[hw/rtl/sgr_fifo.sv]
// ----------------------------------------------------------------------------
// sgr_fifo
// Short work queue between parser and emitter.
// ----------------------------------------------------------------------------
module sgr_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sgr_pkg::sgr_entry_t push_data,
    input  logic                pop,
    output sgr_pkg::sgr_entry_t head,
    output logic                not_empty,
    output logic                full
);

    sgr_pkg::sgr_entry_t mem [sgr_pkg::FIFO_DEPTH];

    logic [sgr_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [sgr_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [sgr_pkg::FIFO_CW-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == sgr_pkg::FIFO_CW'(sgr_pkg::FIFO_DEPTH));
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");
`endif

endmodule

[hw/rtl/sgr_back.sv]
// ----------------------------------------------------------------------------
// sgr_back
// Result emitter: expands queued work into output beats behind a register.
// ----------------------------------------------------------------------------
module sgr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sgr_pkg::sgr_entry_t head,
    input  logic                head_valid,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata,   // out_byte[7:0], fore_rgb[31:8], back_rgb[55:32]
    output logic                m_tuser,   // is_line_end
    output logic                m_tlast    // last_of_run
);

    logic               out_valid_reg;
    logic [7:0]         byte_reg,  byte_next;
    sgr_pkg::rgb_t      fore_reg;
    sgr_pkg::rgb_t      back_reg;
    logic               end_reg,   end_next;
    logic               last_reg,  last_next;
    logic               phase_reg, phase_next;
    logic               load;

    assign load = !out_valid_reg || m_tready;

    always_comb
    begin
        pop        = 1'b0;
        phase_next = phase_reg;
        byte_next  = 8'd0;
        end_next   = 1'b1;
        last_next  = 1'b1;
        if (load && head_valid)
        begin
            if (head.has_text && !phase_reg)
            begin
                byte_next = head.out_byte;
                end_next  = 1'b0;
                last_next = !head.has_end;
                if (head.has_end)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    pop = 1'b1;
                end
            end
            else
            begin
                pop        = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= head_valid;
            end
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            byte_reg <= byte_next;
            fore_reg <= head.fore_rgb;
            back_reg <= head.back_rgb;
            end_reg  <= end_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {back_reg, fore_reg, byte_reg};
    assign m_tuser  = end_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata[7:0] == 8'd0))
        else $error("line-end beat not last or nonzero byte");

    a_phase_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> head_valid)
        else $error("second beat pending with empty queue");

    a_text_then_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser))
        else $error("text beat without last not followed by line end");
`endif

endmodule

[dv/ansi_sgr_color_parser_tb.sv]
// ----------------------------------------------------------------------------
// ansi_sgr_color_parser_tb
// Stream-level test of the SGR color parser. Text bytes, escape sequences,
// broken sequences and end-of-text markers are sent in beats. A local model
// of the parser computes the colored bytes and line ends that each beat
// should produce. Every output beat is checked field by field against them.
// ----------------------------------------------------------------------------
module ansi_sgr_color_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_ITEMS = 2000;
    localparam int  CYCLE_LIMIT  = 1_000_000;
    localparam int  DRAIN_CYCLES = 16;
    localparam int  MAX_IDLE     = 13;
    localparam int  LONG_HOLD    = 60;
    localparam int  REPORT_MAX   = 10;

    // Characters that steer the parser
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_CSI     = "[";
    localparam logic [7:0] CH_SEP     = ";";
    localparam logic [7:0] CH_SGR_END = "m";
    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_NINE    = "9";

    typedef enum logic [1:0] {
        ST_TEXT,
        ST_ESC,
        ST_PARAMS
    } scan_state_t;

    // One colored character or line end as it leaves the block
    typedef struct packed {
        logic [7:0]    ch;
        sgr_pkg::rgb_t fg;
        sgr_pkg::rgb_t bg;
        logic          eol;
        logic          last;
    } glyph_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Model state
    scan_state_t        scan_st;
    sgr_pkg::sgr_attr_t shown_attr;
    sgr_pkg::sgr_attr_t staged_attr;
    int                 code_acc;
    logic               got_digit;
    logic               got_code;

    glyph_t      glyph_q[$];
    glyph_t      want;

    int          mismatches  = 0;
    int          items_sent  = 0;
    int          cycle_cnt   = 0;
    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;
    int          hold_cycles = 0;
    bit          hold_active;

    ansi_sgr_color_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
                     glyph_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model of the parser
    // ------------------------------------------------------------------------
    function automatic sgr_pkg::rgb_t palette(input bit vivid, input int idx);
        case ({vivid, idx[2:0]})
            4'h0: return 24'h000000;
            4'h1: return 24'h800000;
            4'h2: return 24'h008000;
            4'h3: return 24'h808000;
            4'h4: return 24'h000080;
            4'h5: return 24'h800080;
            4'h6: return 24'h008080;
            4'h7: return 24'hC0C0C0;
            4'h8: return 24'h808080;
            4'h9: return 24'hFF0000;
            4'hA: return 24'h00FF00;
            4'hB: return 24'hFFFF00;
            4'hC: return 24'h0000FF;
            4'hD: return 24'hFF00FF;
            4'hE: return 24'h00FFFF;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    function automatic sgr_pkg::sgr_attr_t stage_code(input int code,
                                                      input sgr_pkg::sgr_attr_t a);
        sgr_pkg::sgr_attr_t r;
        r = a;
        if (code == sgr_pkg::CODE_RESET)
        begin
            r.fore = sgr_pkg::DEFAULT_FORE;
            r.back = sgr_pkg::DEFAULT_BACK;
            r.bold = 1'b0;
        end
        else if (code == sgr_pkg::CODE_BOLD)
            r.bold = 1'b1;
        else if (code == sgr_pkg::CODE_BOLD_OFF)
            r.bold = 1'b0;
        else if (code >= sgr_pkg::CODE_FG_LO && code <= sgr_pkg::CODE_FG_HI)
            r.fore = palette(a.bold, code - sgr_pkg::CODE_FG_LO);  // bold picks bright set
        else if (code >= sgr_pkg::CODE_BG_LO && code <= sgr_pkg::CODE_BG_HI)
            r.back = palette(1'b0, code - sgr_pkg::CODE_BG_LO);
        else if (code >= sgr_pkg::CODE_FGB_LO && code <= sgr_pkg::CODE_FGB_HI)
            r.fore = palette(1'b1, code - sgr_pkg::CODE_FGB_LO);
        else if (code >= sgr_pkg::CODE_BGB_LO && code <= sgr_pkg::CODE_BGB_HI)
            r.back = palette(1'b1, code - sgr_pkg::CODE_BGB_LO);
        return r;
    endfunction

    task automatic clear_model();
        scan_st          = ST_TEXT;
        shown_attr.fore  = sgr_pkg::DEFAULT_FORE;
        shown_attr.back  = sgr_pkg::DEFAULT_BACK;
        shown_attr.bold  = 1'b0;
        staged_attr      = shown_attr;
        code_acc         = 0;
        got_digit        = 1'b0;
        got_code         = 1'b0;
    endtask

    // Plain byte or start of a new sequence
    task automatic plain_char(input logic [7:0] b, output logic shown);
        shown   = (b != CH_ESC);
        scan_st = (b == CH_ESC) ? ST_ESC : ST_TEXT;
    endtask

    task automatic take_char(input logic [7:0] b, output logic shown);
        int sum;
        shown = 1'b0;
        case (scan_st)
            ST_ESC:
            begin
                if (b == CH_CSI)
                begin
                    scan_st     = ST_PARAMS;
                    staged_attr = shown_attr;
                    code_acc    = 0;
                    got_digit   = 1'b0;
                    got_code    = 1'b0;
                end
                else
                    plain_char(b, shown);
            end
            ST_PARAMS:
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    sum       = code_acc * 10 + int'(b - CH_ZERO);
                    code_acc  = (sum > 1023) ? 1023 : sum;
                    got_digit = 1'b1;
                end
                else if (b == CH_SEP || b == CH_SGR_END)
                begin
                    if (got_digit)
                    begin
                        staged_attr = stage_code(code_acc, staged_attr);
                        got_code    = 1'b1;
                    end
                    code_acc  = 0;
                    got_digit = 1'b0;
                    if (b == CH_SGR_END)
                    begin
                        // a list with no digits at all means reset
                        if (!got_code)
                            staged_attr = stage_code(sgr_pkg::CODE_RESET, staged_attr);
                        shown_attr = staged_attr;
                        got_code   = 1'b0;
                        scan_st    = ST_TEXT;
                    end
                end
                else
                    plain_char(b, shown);   // sequence aborted, byte is text
            end
            default:
                plain_char(b, shown);
        endcase
    endtask

    task automatic render_item(input logic [7:0] b, input logic has_byte,
                               input logic eot);
        logic shown;
        shown = 1'b0;
        if (has_byte)
            take_char(b, shown);
        if (shown)
            glyph_q.push_back('{ch: b, fg: shown_attr.fore, bg: shown_attr.back,
                                eol: 1'b0, last: !eot});
        if (eot)
        begin
            glyph_q.push_back('{ch: 8'h00, fg: shown_attr.fore, bg: shown_attr.back,
                                eol: 1'b1, last: 1'b1});
            clear_model();
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: stall generation and checking
    // ------------------------------------------------------------------------
    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            wait (hold_cycles > 0);
            @(posedge clk);
            hold_active = 1'b1;
            repeat (hold_cycles) @(posedge clk);
            hold_active = 1'b0;
            hold_cycles = 0;
        end
    end

    initial
    begin
        int wait_n;
        m_tready = 1'b0;
        forever
        begin
            wait_n = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            @(negedge clk);
            if (wait_n > 0 || hold_active)
            begin
                m_tready <= 1'b0;
                repeat (wait_n) @(negedge clk);
                while (hold_active) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic check_field(input string name, input logic [23:0] exp_v,
                               input logic [23:0] got_v);
        if (exp_v !== got_v)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %h got %h", $realtime, name,
                         exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (glyph_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected beat, tdata %h tuser %b tlast %b",
                             $realtime, m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = glyph_q.pop_front();
                check_field("out_byte",    24'(want.ch),   24'(m_tdata[7:0]));
                check_field("fore_rgb",    want.fg,        m_tdata[31:8]);
                check_field("back_rgb",    want.bg,        m_tdata[55:32]);
                check_field("is_line_end", 24'(want.eol),  24'(m_tuser));
                check_field("last_of_run", 24'(want.last), 24'(m_tlast));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] data, input logic has_byte,
                             input logic eot);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= eot;
        do @(posedge clk); while (!s_tready);
        render_item(data, has_byte, eot);
        if (has_byte || eot)
            items_sent++;
    endtask

    task automatic send_text(input string s, input bit eot_at_end);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b1, eot_at_end && (i == s.len() - 1));
    endtask

    // Drop valid and let every outstanding beat come out
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (glyph_q.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_char();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    // -1 stands for an empty field between separators
    function automatic int pick_code();
        case ($urandom_range(0, 11))
            0:       return sgr_pkg::CODE_RESET;
            1:       return sgr_pkg::CODE_BOLD;
            2:       return sgr_pkg::CODE_BOLD_OFF;
            3, 4:    return sgr_pkg::CODE_FG_LO + $urandom_range(0, 7);
            5:       return sgr_pkg::CODE_BG_LO + $urandom_range(0, 7);
            6:       return sgr_pkg::CODE_FGB_LO + $urandom_range(0, 7);
            7:       return sgr_pkg::CODE_BGB_LO + $urandom_range(0, 7);
            8:       return $urandom_range(0, 1023);
            9:       return $urandom_range(1024, 999999);    // saturates
            10:      return -1;
            default: return $urandom_range(0, 120);
        endcase
    endfunction

    task automatic send_sgr(input bit complete);
        int         n;
        int         code;
        string      digits;
        logic [7:0] stop;
        n = $urandom_range(0, 4);
        send_beat(CH_ESC, 1'b1, 1'b0);
        send_beat(CH_CSI, 1'b1, 1'b0);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                send_beat(CH_SEP, 1'b1, 1'b0);
            code = pick_code();
            if (code >= 0)
            begin
                digits = $sformatf("%0d", code);
                if ($urandom_range(0, 7) == 0)
                    digits = {"0", digits};
                send_text(digits, 1'b0);
            end
        end
        if (complete)
            stop = CH_SGR_END;
        else
            do stop = 8'($urandom_range(0, 255));
            while ((stop >= CH_ZERO && stop <= CH_NINE) || stop == CH_SEP ||
                   stop == CH_SGR_END);
        send_beat(stop, 1'b1, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_plain_bytes();
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);      // byte plus line end
        send_beat(8'h5A, 1'b0, 1'b0);      // empty beat, absorbed
        send_beat(8'hA5, 1'b0, 1'b1);      // bare end marker
        settle();
    endtask

    task automatic test_escape_sequences();
        send_text("\033[1;31mA", 1'b0);         // bold then normal fg -> bright
        send_text("\033\033[;mB", 1'b0);        // ESC restarts; empty list resets
        send_text("\033[9999;4x", 1'b0);        // saturated code, aborted list
        send_text("\033[", 1'b1);               // unfinished at end of text
        settle();
    endtask

    // Sink holds off while the source keeps pushing, so the queue fills
    // and s_tready has to drop
    task automatic test_output_stall();
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        hold_cycles = LONG_HOLD;
        repeat (24) send_beat(rand_char(), 1'b1, $urandom_range(0, 3) == 0);
        settle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_texts();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 12))
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                        send_sgr(1'b1);
                    5, 6, 7:
                        repeat ($urandom_range(1, 6)) send_beat(rand_char(), 1'b1, 1'b0);
                    8:
                    begin
                        if ($urandom_range(0, 1) == 0)
                            send_sgr(1'b0);
                        else
                        begin
                            send_beat(CH_ESC, 1'b1, 1'b0);
                            send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                        end
                    end
                    default:
                        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                endcase
            end
            case ($urandom_range(0, 3))
                0, 1:
                    send_beat(rand_char(), 1'b1, 1'b1);
                2:
                    send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                default:
                begin
                    send_beat(CH_ESC, 1'b1, 1'b0);
                    send_beat(CH_CSI, 1'b1, 1'b1);
                end
            endcase
            if ($urandom_range(0, 19) == 0)
                settle();
        end
        settle();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        clear_model();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_plain_bytes();
        test_escape_sequences();
        test_output_stall();
        test_random_texts();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
